### src/stg_pkg.sv
package stg_pkg;

  localparam int DATA_W     = 32;
  localparam int RAMP_BITS  = 19;
  localparam int RAMP_N     = RAMP_BITS + 1;
  localparam int RAMP_CNT_W = $clog2(RAMP_N);
  localparam int DIV_CNT_W  = $clog2(DATA_W);
  localparam int CFG_IDX_W  = 2;

  localparam logic [DATA_W-1:0] RAMP_SPAN = DATA_W'(1) << RAMP_BITS;
  localparam logic [DATA_W-1:0] SLOW_RESET = DATA_W'(4000);
  localparam logic [DATA_W-1:0] FAST_RESET = DATA_W'(400);

  localparam logic [CFG_IDX_W-1:0] CFG_SLOW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FAST    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = CFG_IDX_W'(2);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_LIN,
    S_SPENT,
    S_LEFT,
    S_RAMP,
    S_ADVANCE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_result_t;

endpackage

### src/stg_in_if.sv
interface stg_in_if;
  import stg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] move_steps;
  logic [DATA_W-1:0]        move_duration;
  logic [DATA_W-1:0]        elapsed_us;

  modport source (output valid, output req_type, output move_steps,
                  output move_duration, output elapsed_us, input ready);
  modport sink (input valid, input req_type, input move_steps,
                input move_duration, input elapsed_us, output ready);
endinterface

### src/stg_out_if.sv
interface stg_out_if;
  import stg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DATA_W-1:0]        step_time;
  logic                     no_step;
  logic                     dir_level;
  logic signed [DATA_W-1:0] position;

  modport source (output valid, output step_time, output no_step,
                  output dir_level, output position, input ready);
  modport sink (input valid, input step_time, input no_step,
                input dir_level, input position, output ready);
endinterface

### src/stg_divider.sv
module stg_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [stg_pkg::DATA_W-1:0]    dividend,
  input  logic [stg_pkg::DATA_W-1:0]    divisor,
  output logic                          done,
  output stg_pkg::div_result_t          result
);
  import stg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    dvs_r, dvs_nxt;
  logic [DATA_W:0]      trial;
  logic                 fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial    = {rem_r, quo_r[DATA_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DATA_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DATA_W'(trial - {1'b0, dvs_r}) : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done             = done_r;
  assign result.quotient  = quo_r;
  assign result.remainder = rem_r;

endmodule

### src/stg_ramp_mul.sv
module stg_ramp_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [stg_pkg::DATA_W-1:0]    ramp_t,
  input  logic [stg_pkg::DATA_W-1:0]    slow_period,
  input  logic [stg_pkg::DATA_W-1:0]    fast_period,
  output logic                          done,
  output logic [stg_pkg::DATA_W-1:0]    period
);
  import stg_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  fin_r, fin_nxt;
  logic                  done_r, done_nxt;
  logic [RAMP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAMP_BITS:0]    tt_r, tt_nxt;
  logic [DATA_W-1:0]     d_r, d_nxt;
  logic [DATA_W-1:0]     p_r, p_nxt;
  logic                  lsb_r, lsb_nxt;
  logic                  rise_r, rise_nxt;
  logic [DATA_W-1:0]     period_r, period_nxt;
  logic [DATA_W:0]       psum;
  logic [DATA_W:0]       scaled;
  logic [DATA_W+1:0]     up_sum;

  // shift-add over the ramp time bits, lsb first; keeps product >> RAMP_BITS
  always_comb begin
    psum       = {1'b0, p_r} + (tt_r[0] ? {1'b0, d_r} : '0);
    scaled     = {p_r, lsb_r};
    up_sum     = {2'b00, slow_period} + {1'b0, scaled};
    busy_nxt   = busy_r;
    fin_nxt    = 1'b0;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    tt_nxt     = tt_r;
    d_nxt      = d_r;
    p_nxt      = p_r;
    lsb_nxt    = lsb_r;
    rise_nxt   = rise_r;
    period_nxt = period_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = RAMP_CNT_W'(RAMP_N - 1);
      tt_nxt   = (ramp_t > RAMP_SPAN) ? RAMP_SPAN[RAMP_BITS:0] : ramp_t[RAMP_BITS:0];
      rise_nxt = fast_period > slow_period;
      d_nxt    = (fast_period > slow_period) ? fast_period - slow_period
                                             : slow_period - fast_period;
      p_nxt    = '0;
      lsb_nxt  = 1'b0;
    end else if (busy_r) begin
      p_nxt   = psum[DATA_W:1];
      lsb_nxt = psum[0];
      tt_nxt  = tt_r >> 1;
      cnt_nxt = cnt_r - RAMP_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
      if (!rise_r) begin
        period_nxt = slow_period - scaled[DATA_W-1:0];
      end else if (up_sum[DATA_W+1:DATA_W] != 2'b00) begin
        period_nxt = '1;
      end else begin
        period_nxt = up_sum[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tt_r     <= tt_nxt;
    d_r      <= d_nxt;
    p_r      <= p_nxt;
    lsb_r    <= lsb_nxt;
    rise_r   <= rise_nxt;
    period_r <= period_nxt;
  end

  assign done   = done_r;
  assign period = period_r;

endmodule

### src/stepper_step_time_generator.sv
// channel   dir  handshake     payload
// in_if     in   valid/ready   req_type, move_steps, move_duration, elapsed_us
// out_if    out  valid/ready   step_time, no_step, dir_level, position
// cfg_*     in   cfg_we        cfg_index, cfg_data (slow, fast, reverse)
//
// one item at a time; a linear move start runs the serial divider (one
// quotient bit per cycle), a rapid step with a ramp lookup runs the serial
// multiply over RAMP_BITS+1 bits
// rst_n is synchronous; it restores the register defaults and clears all
// motion state. the result register lets the next input in while the
// previous result waits on out_if.ready
module stepper_step_time_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  stg_in_if.sink                        in_if,
  stg_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [stg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stg_pkg::DATA_W-1:0]    cfg_data
);
  import stg_pkg::*;

  state_t state_r, state_nxt;

  logic [DATA_W-1:0] slow_r, fast_r;
  logic              reverse_r;

  logic              req_r;
  logic [DATA_W-1:0] steps_r, dur_r, elapsed_r;

  logic [DATA_W-1:0] axis_r, total_r, done_steps_r, period_r, prem_r, acc_r;
  logic [DATA_W-1:0] last_r, decel_dist_r, decel_t0_r, accel_r, spent_r;
  logic              dir_neg_r, rapid_r, begun_r;
  logic [DATA_W-1:0] when_r;
  logic              none_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_time_r, out_pos_r;
  logic              out_none_r, out_dir_r;

  logic              neg;
  logic [DATA_W-1:0] mag, cur_pos, left;
  logic              div_start, div_done, ramp_start, ramp_done, load_out;
  logic [DATA_W-1:0] ramp_t, ramp_period;
  div_result_t       div_res;

  assign neg     = steps_r[DATA_W-1];
  assign mag     = neg ? DATA_W'(0) - steps_r : steps_r;
  assign cur_pos = dir_neg_r ? axis_r - done_steps_r : axis_r + done_steps_r;
  assign left    = (spent_r < accel_r) ? accel_r - spent_r : '0;

  stg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dur_r),
    .divisor  (mag),
    .done     (div_done),
    .result   (div_res)
  );

  stg_ramp_mul u_ramp (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (ramp_start),
    .ramp_t      (ramp_t),
    .slow_period (slow_r),
    .fast_period (fast_r),
    .done        (ramp_done),
    .period      (ramp_period)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    ramp_start = 1'b0;
    ramp_t     = elapsed_r;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (req_r == REQ_START) begin
          if (mag != '0 && dur_r != '0) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_RESULT;
          end
        end else if (done_steps_r >= total_r) begin
          state_nxt = S_RESULT;
        end else if (!rapid_r) begin
          state_nxt = S_LIN;
        end else if (done_steps_r >= decel_dist_r) begin
          state_nxt = S_SPENT;
        end else if (elapsed_r <= RAMP_SPAN) begin
          ramp_start = 1'b1;
          state_nxt  = S_RAMP;
        end else begin
          state_nxt = S_ADVANCE;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_RESULT;
      end
      S_LIN: state_nxt = S_RESULT;
      S_SPENT: state_nxt = S_LEFT;
      S_LEFT: begin
        ramp_start = 1'b1;
        ramp_t     = left;
        state_nxt  = S_RAMP;
      end
      S_RAMP: begin
        if (ramp_done) state_nxt = S_ADVANCE;
      end
      S_ADVANCE: state_nxt = S_RESULT;
      S_RESULT: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r    <= SLOW_RESET;
      fast_r    <= FAST_RESET;
      reverse_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOW:    slow_r    <= cfg_data;
        CFG_FAST:    fast_r    <= cfg_data;
        CFG_REVERSE: reverse_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_if.valid) begin
      req_r     <= in_if.req_type;
      steps_r   <= in_if.move_steps;
      dur_r     <= in_if.move_duration;
      elapsed_r <= in_if.elapsed_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r       <= '0;
      dir_neg_r    <= 1'b0;
      total_r      <= '0;
      done_steps_r <= '0;
      rapid_r      <= 1'b0;
      period_r     <= '0;
      prem_r       <= '0;
      acc_r        <= '0;
      last_r       <= '0;
      decel_dist_r <= '0;
      decel_t0_r   <= '0;
      begun_r      <= 1'b0;
      accel_r      <= '0;
      spent_r      <= '0;
      when_r       <= '0;
      none_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_DECODE: begin
          if (req_r == REQ_START) begin
            none_r  <= (mag == '0);
            axis_r  <= cur_pos;
            total_r <= mag;
            rapid_r <= (dur_r == '0);
            if (mag != '0) begin
              dir_neg_r <= neg;
            end
            if (mag != '0 && dur_r == '0) begin
              period_r     <= slow_r;
              decel_dist_r <= mag;
              begun_r      <= 1'b0;
              done_steps_r <= DATA_W'(1);
              last_r       <= slow_r;
              when_r       <= slow_r;
            end else begin
              done_steps_r <= '0;
              last_r       <= '0;
              when_r       <= '0;
            end
          end else if (done_steps_r >= total_r) begin
            axis_r       <= cur_pos;
            done_steps_r <= '0;
            none_r       <= 1'b1;
            when_r       <= '0;
          end else if (!rapid_r) begin
            none_r <= 1'b0;
            last_r <= last_r + period_r;
            acc_r  <= acc_r + prem_r;
          end else if (done_steps_r >= decel_dist_r) begin
            none_r <= 1'b0;
            if (!begun_r) begin
              decel_t0_r <= elapsed_r;
              begun_r    <= 1'b1;
            end
          end else if (elapsed_r <= RAMP_SPAN) begin
            none_r       <= 1'b0;
            decel_dist_r <= total_r - done_steps_r;
            accel_r      <= elapsed_r;
          end else begin
            none_r <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            period_r     <= div_res.quotient;
            prem_r       <= div_res.remainder;
            acc_r        <= '0;
            done_steps_r <= DATA_W'(1);
            last_r       <= div_res.quotient;
            when_r       <= div_res.quotient;
          end
        end
        S_LIN: begin
          done_steps_r <= done_steps_r + DATA_W'(1);
          if (acc_r >= total_r) begin
            acc_r  <= acc_r - total_r;
            last_r <= last_r + DATA_W'(1);
            when_r <= last_r + DATA_W'(1);
          end else begin
            when_r <= last_r;
          end
        end
        S_SPENT: begin
          spent_r <= (elapsed_r >= decel_t0_r) ? elapsed_r - decel_t0_r : '0;
        end
        S_RAMP: begin
          if (ramp_done) period_r <= ramp_period;
        end
        S_ADVANCE: begin
          last_r       <= last_r + period_r;
          when_r       <= last_r + period_r;
          done_steps_r <= done_steps_r + DATA_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_time_r <= when_r;
      out_none_r <= none_r;
      out_dir_r  <= ~dir_neg_r ^ reverse_r;
      out_pos_r  <= cur_pos;
    end
  end

  assign in_if.ready      = (state_r == S_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.step_time = out_time_r;
  assign out_if.no_step   = out_none_r;
  assign out_if.dir_level = out_dir_r;
  assign out_if.position  = out_pos_r;

endmodule

### bench/stepper_step_time_generator_tb.sv
module stepper_step_time_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stg_pkg::*;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] move_steps;
    logic [DATA_W-1:0] move_duration;
    logic [DATA_W-1:0] elapsed_us;
  } step_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] step_time;
    logic              no_step;
    logic              dir_level;
    logic [DATA_W-1:0] position;
  } step_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  stg_in_if in_ch ();
  stg_out_if out_ch ();

  stepper_step_time_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // axis predictor state
  logic [DATA_W-1:0] slow_per, fast_per;
  logic              rev_dir;
  logic [DATA_W-1:0] axis_pos, move_len, steps_taken, cur_period, period_rem, rem_sum;
  logic [DATA_W-1:0] prev_time, decel_at, decel_t0, accel_span;
  logic              dir_neg, rapid_move, decel_on;

  step_result_t predicted_steps[$];
  int  error_count = 0;
  bit  no_idle = 1'b0;
  logic hold_request = 1'b0;
  logic hold_active = 1'b0;

  function automatic logic [DATA_W-1:0] ramp_lookup(logic [DATA_W-1:0] t);
    logic [63:0] tt, d, v;
    tt = (t > RAMP_SPAN) ? 64'(RAMP_SPAN) : 64'(t);
    if (fast_per <= slow_per) begin
      d = 64'(slow_per - fast_per);
      v = (d * tt) >> RAMP_BITS;
      return slow_per - v[DATA_W-1:0];
    end
    d = 64'(fast_per - slow_per);
    v = 64'(slow_per) + ((d * tt) >> RAMP_BITS);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] axis_now();
    return dir_neg ? axis_pos - steps_taken : axis_pos + steps_taken;
  endfunction

  function automatic step_result_t advance_axis(step_req_t r);
    step_result_t res;
    logic neg, none;
    logic [DATA_W-1:0] mag, nxt, spent, left, when_t;
    none = 1'b0;
    when_t = '0;
    if (r.req_type == REQ_START) begin
      neg = r.move_steps[DATA_W-1];
      mag = neg ? (32'd0 - r.move_steps) : r.move_steps;
      axis_pos = axis_now();
      steps_taken = '0;
      move_len = mag;
      rapid_move = (r.move_duration == '0);
      prev_time = '0;
      if (mag != '0) begin
        dir_neg = neg;
        if (!rapid_move) begin
          cur_period = r.move_duration / mag;
          period_rem = r.move_duration % mag;
          rem_sum = '0;
        end else begin
          cur_period = slow_per;
          decel_at = mag;
          decel_on = 1'b0;
        end
        steps_taken = 32'd1;
        prev_time = cur_period;
        when_t = cur_period;
      end else begin
        none = 1'b1;
      end
    end else if (steps_taken >= move_len) begin
      axis_pos = axis_now();
      steps_taken = '0;
      none = 1'b1;
    end else if (!rapid_move) begin
      nxt = prev_time + cur_period;
      rem_sum = rem_sum + period_rem;
      if (rem_sum >= move_len) begin
        rem_sum = rem_sum - move_len;
        nxt = nxt + 32'd1;
      end
      prev_time = nxt;
      steps_taken = steps_taken + 32'd1;
      when_t = nxt;
    end else begin
      if (steps_taken >= decel_at) begin
        if (!decel_on) begin
          decel_t0 = r.elapsed_us;
          decel_on = 1'b1;
        end
        spent = (r.elapsed_us >= decel_t0) ? r.elapsed_us - decel_t0 : '0;
        left = (spent < accel_span) ? accel_span - spent : '0;
        cur_period = ramp_lookup(left);
      end else if (r.elapsed_us <= RAMP_SPAN) begin
        cur_period = ramp_lookup(r.elapsed_us);
        decel_at = move_len - steps_taken;
        accel_span = r.elapsed_us;
      end
      prev_time = prev_time + cur_period;
      steps_taken = steps_taken + 32'd1;
      when_t = prev_time;
    end
    res.step_time = none ? '0 : when_t;
    res.no_step = none;
    res.dir_level = ~dir_neg ^ rev_dir;
    res.position = axis_now();
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(step_req_t r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= r.req_type;
    in_ch.move_steps <= r.move_steps;
    in_ch.move_duration <= r.move_duration;
    in_ch.elapsed_us <= r.elapsed_us;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted_steps.push_back(advance_axis(r));
  endtask

  task automatic send_start(logic [DATA_W-1:0] steps, logic [DATA_W-1:0] dur);
    send_item({REQ_START, steps, dur, 32'($urandom())});
  endtask

  task automatic send_next(logic [DATA_W-1:0] elapsed);
    send_item({REQ_NEXT, 32'($urandom()), 32'($urandom()), elapsed});
  endtask

  // elapsed mostly tracks the scheduled step time, sometimes jumps or goes back
  task automatic follow_move(int n);
    logic [DATA_W-1:0] e;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75) e = prev_time + $urandom_range(0, 40);
      else if (r < 85) e = prev_time - $urandom_range(0, 3000);
      else if (r < 95) e = $urandom_range(0, 2 * RAMP_SPAN);
      else e = $urandom();
      send_next(e);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (predicted_steps.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SLOW:    slow_per = data;
      CFG_FAST:    fast_per = data;
      CFG_REVERSE: rev_dir = data[0];
      default: ;
    endcase
  endtask

  task automatic set_phase(logic [DATA_W-1:0] slow, logic [DATA_W-1:0] fast, logic rev);
    settle();
    write_reg(CFG_SLOW, slow);
    write_reg(CFG_FAST, fast);
    write_reg(CFG_REVERSE, {31'b0, rev});
  endtask

  task automatic check_result();
    step_result_t want;
    if (predicted_steps.size() == 0) begin
      $error("unexpected result transaction: step_time %0d", out_ch.step_time);
      error_count++;
    end else begin
      want = predicted_steps.pop_front();
      if (out_ch.step_time !== want.step_time) begin
        $error("step_time: expected %0d, got %0d", want.step_time, out_ch.step_time);
        error_count++;
      end
      if (out_ch.no_step !== want.no_step) begin
        $error("no_step: expected %0d, got %0d", want.no_step, out_ch.no_step);
        error_count++;
      end
      if (out_ch.dir_level !== want.dir_level) begin
        $error("dir_level: expected %0d, got %0d", want.dir_level, out_ch.dir_level);
        error_count++;
      end
      if (out_ch.position !== want.position) begin
        $error("position: expected %0d, got %0d", $signed(want.position), out_ch.position);
        error_count++;
      end
    end
  endtask

  // result side
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) check_result();
      if (hold == 0 && $urandom_range(0, 4) == 0) hold = idle_len();
      if (hold_active || hold > 0) begin
        out_ch.ready <= 1'b0;
        if (hold > 0) hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (300) @(posedge clk);
    hold_active <= 1'b0;
  end

  task automatic test_reset_state();
    send_next($urandom());
  endtask

  task automatic test_linear_moves();
    send_start(32'd3, 32'd10);
    follow_move(3);
    send_start(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    follow_move(2);
    send_start(32'd5, 32'd2);
    follow_move(5);
  endtask

  task automatic test_rapid_moves();
    send_start(32'd6, 32'd0);
    repeat (4) send_next(prev_time);
    // elapsed below the captured deceleration start
    send_next(32'd0);
    send_next(prev_time);
  endtask

  task automatic test_special_counts();
    send_start(32'd0, 32'd100);
    send_next(32'd0);
    send_start(32'h8000_0000, 32'd1000);
    send_next(32'd0);
    send_start(32'h7FFF_FFFF, 32'd0);
    send_next(prev_time);
  endtask

  task automatic test_back_pressure();
    no_idle = 1'b1;
    hold_request <= 1'b1;
    send_start(32'd40, 32'd0);
    follow_move(24);
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [DATA_W-1:0] s, mag, steps, dur;
    int sent, kind, n;
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_phase(SLOW_RESET, FAST_RESET, 1'b1);
        1: begin
          s = $urandom_range(50, 5000);
          set_phase(s, $urandom_range(1, s), 1'b0);
        end
        2: set_phase(32'hFFFF_FFFF, 32'd1, 1'b1);
        3: set_phase(32'd1, 32'd1, 1'b0);
        4: set_phase(32'd1, 32'hFFFF_FFFF, 1'b1);
        5: set_phase($urandom() | 1, $urandom() | 1, 1'($urandom_range(0, 1)));
        6: begin
          s = $urandom_range(10, 200);
          set_phase(s, s + $urandom_range(1, 300), 1'b0);
        end
        default: set_phase(SLOW_RESET, FAST_RESET, 1'b0);
      endcase
      no_idle = (phase == 3);
      while (sent < 200 * (phase + 1)) begin
        kind = $urandom_range(0, 99);
        mag = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 400) : $urandom_range(1, 40);
        if (kind < 5) mag = '0;
        steps = $urandom_range(0, 1) ? 32'd0 - mag : mag;
        if (kind < 45) dur = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000)
                                                         : ($urandom() | 1);
        else dur = '0;
        if (kind >= 90) begin
          steps = $urandom();
          dur = $urandom_range(0, 1) ? $urandom() : 0;
          mag = $urandom_range(0, 5);
        end
        send_start(steps, dur);
        n = (mag > 0) ? int'(mag) - 1 + $urandom_range(0, 3) : $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
        follow_move(n);
        sent += n + 1;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    slow_per = SLOW_RESET;
    fast_per = FAST_RESET;
    rev_dir = 1'b0;
    axis_pos = '0;
    move_len = '0;
    steps_taken = '0;
    cur_period = '0;
    period_rem = '0;
    rem_sum = '0;
    prev_time = '0;
    decel_at = '0;
    decel_t0 = '0;
    accel_span = '0;
    dir_neg = 1'b0;
    rapid_move = 1'b0;
    decel_on = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_START;
    in_ch.move_steps <= '0;
    in_ch.move_duration <= '0;
    in_ch.elapsed_us <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_linear_moves();
    test_rapid_moves();
    test_special_counts();
    test_back_pressure();
    test_random_traffic();

    settle();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### stepper_step_time_generator.f
src/stg_pkg.sv
src/stg_in_if.sv
src/stg_out_if.sv
src/stg_divider.sv
src/stg_ramp_mul.sv
src/stepper_step_time_generator.sv
bench/stepper_step_time_generator_tb.sv
